### design/multi_slot_alarm_matcher_assert.svh
// Assertion macros for the alarm matcher checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef MULTI_SLOT_ALARM_MATCHER_ASSERT_SVH
`define MULTI_SLOT_ALARM_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSAM_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alarm matcher check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSAM_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alarm matcher check failed");

`endif

### design/msam_pkg.sv
// Shared types and constants for the multi-slot alarm matcher.
// No dependencies; imported by every module of the block but msam_ram.
`default_nettype none
package msam_pkg;

	localparam int CMD_W   = 4;
	localparam int SLOT_W  = 4;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int REP_W   = 32;
	localparam int COUNT_W = 5;

	localparam logic [HOUR_W-1:0] MAX_HOUR   = 5'd23;
	localparam logic [MIN_W-1:0]  MAX_MINUTE = 6'd59;

	// register index, taken from paddr[2]
	localparam logic REG_BLOCK_EN   = 1'b0;
	localparam logic REG_AUTO_CHECK = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 4'd0,
		CMD_REMOVE   = 4'd1,
		CMD_ENABLE   = 4'd2,
		CMD_DISABLE  = 4'd3,
		CMD_TOGGLE   = 4'd4,
		CMD_SET_TIME = 4'd5,
		CMD_SET_REP  = 4'd6,
		CMD_TICK     = 4'd7,
		CMD_READ     = 4'd8,
		CMD_CLEAR    = 4'd9
	} msam_cmd_t;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_ADD,
		DP_RM_START,
		DP_SHIFT,
		DP_RM_END,
		DP_SET_ON,
		DP_SET_OFF,
		DP_SET_TIME,
		DP_SET_REP,
		DP_RD_ISSUE,
		DP_TOGGLE,
		DP_READ,
		DP_SCAN_START,
		DP_SCAN_NEXT,
		DP_TICK_HIT,
		DP_TICK_END,
		DP_CLEAR,
		DP_PUSH
	} msam_op_t;

	typedef struct packed {
		msam_op_t op;
	} msam_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             idx_ok;    // slot_index below used count
		logic             time_ok;   // hour/minute in range
		logic             full;      // table has no free slot
		logic             more;      // shift pointer has a successor in use
		logic             scan_vld;  // scan pointer below used count
		logic             scan_hit;  // entry at scan pointer matches tick
		logic             out_free;  // output register can take a result
	} msam_stat_t;

	// result request, ok in bit 0
	typedef struct packed {
		logic [COUNT_W-1:0] slot_count;
		logic [REP_W-1:0]   slot_repeat;
		logic               slot_on;
		logic [MIN_W-1:0]   slot_minute;
		logic [HOUR_W-1:0]  slot_hour;
		logic [SLOT_W-1:0]  pending_slot;
		logic               pending;
		logic [SLOT_W-1:0]  fired_slot;
		logic               fired;
		logic [SLOT_W-1:0]  new_slot;
		logic               ok;
	} msam_res_t;

endpackage
`default_nettype wire

### design/multi_slot_alarm_matcher.sv
// Multi-slot alarm matcher top: APB config registers, controller and datapath.
// Tick and remove walk the table one entry per cycle through the single read port of
// the slot RAMs. Requests are taken one at a time, only while the controller is idle;
// the output register frees the input side early: a result waits there for m_tready.
// Reset (arst_n, async): count, latch, FSM cleared, block_enabled=0, auto_check=1.
`default_nettype none
module multi_slot_alarm_matcher import msam_pkg::*; #(
	parameter int MAX_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // slot_index[3:0] hour[8:4] minute[14:9]
	                                    // repeat_days[46:15] zero[47]
	input  wire logic [3:0]  s_tuser,   // command[3:0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata    // ok[0] new_slot[4:1] fired[5] fired_slot[9:6]
	                                    // pending[10] pending_slot[14:11] slot_hour[19:15]
	                                    // slot_minute[25:20] slot_on[26]
	                                    // slot_repeat[58:27] slot_count[63:59]
);
	logic       blk_en_q;
	logic       auto_chk_q;
	logic       cfg_wr;
	msam_ctl_t  ctl;
	msam_stat_t stat;
	msam_res_t  res;

	// APB: zero wait states, register index in paddr[2]
	// the slot table is never cleared: only entries below the used count are read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_en_q   <= 1'b0;
			auto_chk_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BLOCK_EN:   blk_en_q   <= pwdata[0];
				REG_AUTO_CHECK: auto_chk_q <= pwdata[0];
				default:        blk_en_q   <= blk_en_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BLOCK_EN:   prdata = {31'd0, blk_en_q};
			REG_AUTO_CHECK: prdata = {31'd0, auto_chk_q};
			default:        prdata = '0;
		endcase
	end

	// controller: one request at a time, walks the table for tick and remove
	msam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.blk_en   (blk_en_q),
		.auto_chk (auto_chk_q),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: slot RAMs, pointer, pending latch, result and output registers
	msam_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.in_cmd   (s_tuser),
		.in_idx   (s_tdata[3:0]),
		.in_hour  (s_tdata[8:4]),
		.in_min   (s_tdata[14:9]),
		.in_rep   (s_tdata[46:15]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res)
	);

	assign m_tdata = res;
endmodule
`default_nettype wire

### design/msam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module msam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [ADDR_W-1:0]       waddr,
	input  wire logic [WIDTH-1:0]        wdata,
	input  wire logic [ADDR_W-1:0]       raddr,
	output logic      [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### design/msam_ctrl.sv
// Controller FSM of the alarm matcher: sequences each request through the datapath.
// Depends on msam_pkg.
`default_nettype none
module msam_ctrl import msam_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic       blk_en,
	input  wire logic       auto_chk,
	input  wire msam_stat_t stat,
	output msam_ctl_t       ctl
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT,
		S_SCAN,
		S_RD,
		S_DONE
	} state_t;

	state_t state_q, state_nxt;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		ctl.op    = DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.op    = DP_LOAD;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				state_nxt = S_DONE;
				if (blk_en) begin
					unique case (stat.cmd)
						CMD_ADD: begin
							if (stat.time_ok && !stat.full) ctl.op = DP_ADD;
						end
						CMD_REMOVE: begin
							if (stat.idx_ok) begin
								ctl.op    = DP_RM_START;
								state_nxt = S_SHIFT;
							end
						end
						CMD_ENABLE: begin
							if (stat.idx_ok) ctl.op = DP_SET_ON;
						end
						CMD_DISABLE: begin
							if (stat.idx_ok) ctl.op = DP_SET_OFF;
						end
						CMD_TOGGLE, CMD_READ: begin
							if (stat.idx_ok) begin
								ctl.op    = DP_RD_ISSUE;
								state_nxt = S_RD;
							end
						end
						CMD_SET_TIME: begin
							if (stat.idx_ok && stat.time_ok) ctl.op = DP_SET_TIME;
						end
						CMD_SET_REP: begin
							if (stat.idx_ok) ctl.op = DP_SET_REP;
						end
						CMD_TICK: begin
							if (auto_chk) begin
								ctl.op    = DP_SCAN_START;
								state_nxt = S_SCAN;
							end
						end
						CMD_CLEAR: begin
							ctl.op = DP_CLEAR;
						end
						default: begin
							ctl.op = DP_NOP;
						end
					endcase
				end
			end
			S_SHIFT: begin
				if (stat.more) begin
					ctl.op = DP_SHIFT;
				end else begin
					ctl.op    = DP_RM_END;
					state_nxt = S_DONE;
				end
			end
			S_SCAN: begin
				if (!stat.scan_vld) begin
					ctl.op    = DP_TICK_END;
					state_nxt = S_DONE;
				end else if (stat.scan_hit) begin
					ctl.op    = DP_TICK_HIT;
					state_nxt = S_DONE;
				end else begin
					ctl.op = DP_SCAN_NEXT;
				end
			end
			S_RD: begin
				ctl.op    = (stat.cmd == CMD_TOGGLE) ? DP_TOGGLE : DP_READ;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.op    = DP_PUSH;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule
`default_nettype wire

### design/msam_dp.sv
// Datapath of the alarm matcher: request registers, slot table, scan/shift pointer,
// pending latch and output register. Depends on msam_pkg and msam_ram.
`default_nettype none
module msam_dp import msam_pkg::*; #(
	parameter int MAX_SLOTS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire msam_ctl_t         ctl,
	output msam_stat_t             stat,
	input  wire logic [CMD_W-1:0]  in_cmd,
	input  wire logic [SLOT_W-1:0] in_idx,
	input  wire logic [HOUR_W-1:0] in_hour,
	input  wire logic [MIN_W-1:0]  in_min,
	input  wire logic [REP_W-1:0]  in_rep,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output msam_res_t              m_res
);
	localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int PTR1_W = CNT_W + 1;
	localparam int CMP_W  = CNT_W + SLOT_W;

	// request registers
	logic [CMD_W-1:0]  cmd_q;
	logic [SLOT_W-1:0] idx_q;
	logic [HOUR_W-1:0] hour_q;
	logic [MIN_W-1:0]  min_q;
	logic [REP_W-1:0]  rep_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pidx_q;
	logic              m_tvalid_q;
	msam_res_t         res_q;
	msam_res_t         res_nxt;
	msam_res_t         push_res;
	msam_res_t         out_q;

	// table ports
	logic [IDX_W-1:0]  raddr, waddr;
	logic              we_hour, we_min, we_on, we_rep;
	logic [HOUR_W-1:0] wd_hour, rd_hour;
	logic [MIN_W-1:0]  wd_min, rd_min;
	logic              wd_on, rd_on;
	logic [REP_W-1:0]  wd_rep, rd_rep;

	logic              same_pend;

	msam_ram #(.WIDTH(HOUR_W), .DEPTH(MAX_SLOTS)) u_hour (
		.clk(clk), .we(we_hour), .waddr(waddr), .wdata(wd_hour), .raddr(raddr), .rdata(rd_hour)
	);
	msam_ram #(.WIDTH(MIN_W), .DEPTH(MAX_SLOTS)) u_min (
		.clk(clk), .we(we_min), .waddr(waddr), .wdata(wd_min), .raddr(raddr), .rdata(rd_min)
	);
	msam_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_on (
		.clk(clk), .we(we_on), .waddr(waddr), .wdata(wd_on), .raddr(raddr), .rdata(rd_on)
	);
	msam_ram #(.WIDTH(REP_W), .DEPTH(MAX_SLOTS)) u_rep (
		.clk(clk), .we(we_rep), .waddr(waddr), .wdata(wd_rep), .raddr(raddr), .rdata(rd_rep)
	);

	// status to controller
	always_comb begin
		stat.cmd      = cmd_q;
		stat.idx_ok   = CMP_W'(idx_q) < CMP_W'(count_q);
		stat.time_ok  = (hour_q <= MAX_HOUR) && (min_q <= MAX_MINUTE);
		stat.full     = (PTR1_W'(count_q) >= PTR1_W'(MAX_SLOTS));
		stat.more     = (PTR1_W'(ptr_q) + PTR1_W'(1)) < PTR1_W'(count_q);
		stat.scan_vld = ptr_q < count_q;
		stat.scan_hit = stat.scan_vld && rd_on && (rd_hour == hour_q) && (rd_min == min_q);
		stat.out_free = !m_tvalid_q || m_tready;
	end

	assign same_pend = pend_q && (pidx_q == IDX_W'(ptr_q));

	// table address and write control
	always_comb begin
		raddr   = IDX_W'(ptr_q);
		waddr   = IDX_W'(ptr_q);
		we_hour = 1'b0;
		we_min  = 1'b0;
		we_on   = 1'b0;
		we_rep  = 1'b0;
		wd_hour = hour_q;
		wd_min  = min_q;
		wd_on   = 1'b1;
		wd_rep  = rep_q;
		unique case (ctl.op)
			DP_ADD: begin
				waddr   = IDX_W'(count_q);
				we_hour = 1'b1;
				we_min  = 1'b1;
				we_on   = 1'b1;
				we_rep  = 1'b1;
			end
			DP_RM_START: begin
				raddr = IDX_W'(CMP_W'(idx_q) + CMP_W'(1));
			end
			DP_SHIFT: begin
				// move entry ptr+1 (now on the read port) down to ptr
				we_hour = 1'b1;
				we_min  = 1'b1;
				we_on   = 1'b1;
				we_rep  = 1'b1;
				wd_hour = rd_hour;
				wd_min  = rd_min;
				wd_on   = rd_on;
				wd_rep  = rd_rep;
				raddr   = IDX_W'(PTR1_W'(ptr_q) + PTR1_W'(2));
			end
			DP_SET_ON, DP_SET_OFF: begin
				waddr = IDX_W'(idx_q);
				we_on = 1'b1;
				wd_on = (ctl.op == DP_SET_ON);
			end
			DP_TOGGLE: begin
				waddr = IDX_W'(idx_q);
				we_on = 1'b1;
				wd_on = !rd_on;
			end
			DP_SET_TIME: begin
				waddr   = IDX_W'(idx_q);
				we_hour = 1'b1;
				we_min  = 1'b1;
			end
			DP_SET_REP: begin
				waddr  = IDX_W'(idx_q);
				we_rep = 1'b1;
			end
			DP_RD_ISSUE: begin
				raddr = IDX_W'(idx_q);
			end
			DP_SCAN_START: begin
				raddr = '0;
			end
			DP_SCAN_NEXT: begin
				raddr = IDX_W'(PTR1_W'(ptr_q) + PTR1_W'(1));
			end
			default: begin
				raddr = IDX_W'(ptr_q);
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			pend_q     <= 1'b0;
			pidx_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.op == DP_PUSH) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (ctl.op)
				DP_ADD:        count_q <= count_q + CNT_W'(1);
				DP_RM_START:   ptr_q   <= CNT_W'(idx_q);
				DP_SHIFT:      ptr_q   <= ptr_q + CNT_W'(1);
				DP_RM_END:     count_q <= count_q - CNT_W'(1);
				DP_SCAN_START: ptr_q   <= '0;
				DP_SCAN_NEXT:  ptr_q   <= ptr_q + CNT_W'(1);
				DP_TICK_HIT: begin
					if (!same_pend) begin
						pend_q <= 1'b1;
						pidx_q <= IDX_W'(ptr_q);
					end
				end
				DP_CLEAR: begin
					pend_q <= 1'b0;
					pidx_q <= '0;
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	// result build; latch state and count join the result on push
	always_comb begin
		res_nxt               = res_q;
		push_res              = res_q;
		push_res.pending      = pend_q;
		push_res.pending_slot = SLOT_W'(pidx_q);
		push_res.slot_count   = COUNT_W'(count_q);
		unique case (ctl.op)
			DP_LOAD: begin
				res_nxt = '0;
			end
			DP_ADD: begin
				res_nxt.ok       = 1'b1;
				res_nxt.new_slot = SLOT_W'(count_q);
			end
			DP_RM_END, DP_SET_ON, DP_SET_OFF, DP_TOGGLE, DP_SET_TIME, DP_SET_REP,
			DP_TICK_END, DP_CLEAR: begin
				res_nxt.ok = 1'b1;
			end
			DP_TICK_HIT: begin
				res_nxt.ok = 1'b1;
				if (!same_pend) begin
					res_nxt.fired      = 1'b1;
					res_nxt.fired_slot = SLOT_W'(ptr_q);
				end
			end
			DP_READ: begin
				res_nxt.ok          = 1'b1;
				res_nxt.slot_hour   = rd_hour;
				res_nxt.slot_minute = rd_min;
				res_nxt.slot_on     = rd_on;
				res_nxt.slot_repeat = rd_rep;
			end
			default: begin
				res_nxt = res_q;
			end
		endcase
	end

	// payload: request capture, result register, output register
	always_ff @(posedge clk) begin
		res_q <= res_nxt;
		if (ctl.op == DP_LOAD) begin
			cmd_q  <= in_cmd;
			idx_q  <= in_idx;
			hour_q <= in_hour;
			min_q  <= in_min;
			rep_q  <= in_rep;
		end
		if (ctl.op == DP_PUSH) begin
			out_q <= push_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_res    = out_q;
endmodule
`default_nettype wire

### design/msam_checker.sv
// Port-level checks on the alarm matcher result stream, bound to the top level.
// Depends on msam_pkg and multi_slot_alarm_matcher_assert.svh.
`default_nettype none
`include "multi_slot_alarm_matcher_assert.svh"
module msam_checker import msam_pkg::*; #(
	parameter int MAX_SLOTS = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);
	msam_res_t r;

	assign r = m_tdata;

	// a stalled result holds
	`MSAM_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a fire always leaves that slot latched
	`MSAM_IMP(a_fire_latched, m_tvalid && r.fired,
		r.ok && r.pending && (r.pending_slot == r.fired_slot))

	// the latch index is cleared with the flag
	`MSAM_IMP(a_pend_idle, m_tvalid && !r.pending, r.pending_slot == '0)

	// failed requests report nothing else
	`MSAM_IMP(a_fail_quiet, m_tvalid && !r.ok,
		!r.fired && (r.new_slot == '0) && (r.slot_repeat == '0) && !r.slot_on)

	`MSAM_IMP(a_count_max, m_tvalid, int'(r.slot_count) <= MAX_SLOTS)
endmodule

bind multi_slot_alarm_matcher msam_checker #(.MAX_SLOTS(MAX_SLOTS)) u_msam_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/multi_slot_alarm_matcher_tb.sv
// Testbench for the multi-slot alarm matcher: APB setup, request/result streams and a
// cycle-free predictor of the slot table and pending latch. Needs msam_pkg and the RTL.
`timescale 1ns / 100ps
module multi_slot_alarm_matcher_tb;
	import msam_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(int'(CMD_CLEAR) + 1);
	localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = '1;

	// one request as the sender sees it; drain_first holds it back until all results are in
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [REP_W-1:0]  repeat_word;
		logic              drain_first;
	} alarm_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // slot_index[3:0] hour[8:4] minute[14:9] repeat_days[46:15]
	logic [3:0]  s_tuser = '0;   // command[3:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // ok, new_slot, fired, fired_slot, pending, pending_slot,
	                             // slot_hour, slot_minute, slot_on, slot_repeat, slot_count

	multi_slot_alarm_matcher #(.MAX_SLOTS(SLOTS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// predictor copy of the block: config, slot table, used count, pending latch
	logic              cfg_block_en = 1'b0;
	logic              cfg_auto_check = 1'b1;
	logic [HOUR_W-1:0] tbl_hour [SLOTS];
	logic [MIN_W-1:0]  tbl_minute [SLOTS];
	logic              tbl_on [SLOTS];
	logic [REP_W-1:0]  tbl_repeat [SLOTS];
	int                slots_used = 0;
	logic              pending_on = 1'b0;
	logic [SLOT_W-1:0] pending_at = '0;

	alarm_req_t  request_queue[$];
	msam_res_t   expected_results[$];
	alarm_req_t  driven_req;
	logic        item_taken = 1'b0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          tx_calm = 0;
	int          rx_calm = 0;
	int          mismatches = 0;
	msam_res_t   want;
	msam_res_t   got;
	logic [HOUR_W-1:0] pool_hour [4];
	logic [MIN_W-1:0]  pool_minute [4];

	// Applies one request to the predictor state and returns the result it must produce.
	function automatic msam_res_t predict_alarm_result(input alarm_req_t r);
		msam_res_t res;
		logic      idx_ok;
		logic      time_ok;
		int        hit;
		res = '0;
		idx_ok = int'(r.slot) < slots_used;
		time_ok = (r.hour <= MAX_HOUR) && (r.minute <= MAX_MINUTE);
		hit = -1;
		if (cfg_block_en) begin
			case (r.cmd)
			CMD_ADD: begin
				if (time_ok && slots_used < SLOTS) begin
					tbl_hour[slots_used] = r.hour;
					tbl_minute[slots_used] = r.minute;
					tbl_on[slots_used] = 1'b1;
					tbl_repeat[slots_used] = r.repeat_word;
					res.new_slot = SLOT_W'(slots_used);
					slots_used++;
					res.ok = 1'b1;
				end
			end
			CMD_REMOVE: begin
				// later slots move down; the pending latch stays as it was
				if (idx_ok) begin
					for (int i = int'(r.slot); i + 1 < slots_used; i++) begin
						tbl_hour[i] = tbl_hour[i+1];
						tbl_minute[i] = tbl_minute[i+1];
						tbl_on[i] = tbl_on[i+1];
						tbl_repeat[i] = tbl_repeat[i+1];
					end
					slots_used--;
					res.ok = 1'b1;
				end
			end
			CMD_ENABLE, CMD_DISABLE, CMD_TOGGLE: begin
				if (idx_ok) begin
					if (r.cmd == CMD_ENABLE)
						tbl_on[r.slot] = 1'b1;
					else if (r.cmd == CMD_DISABLE)
						tbl_on[r.slot] = 1'b0;
					else
						tbl_on[r.slot] = ~tbl_on[r.slot];
					res.ok = 1'b1;
				end
			end
			CMD_SET_TIME: begin
				if (idx_ok && time_ok) begin
					tbl_hour[r.slot] = r.hour;
					tbl_minute[r.slot] = r.minute;
					res.ok = 1'b1;
				end
			end
			CMD_SET_REP: begin
				if (idx_ok) begin
					tbl_repeat[r.slot] = r.repeat_word;
					res.ok = 1'b1;
				end
			end
			CMD_TICK: begin
				if (cfg_auto_check) begin
					res.ok = 1'b1;
					for (int i = 0; i < slots_used; i++) begin
						if (hit < 0 && tbl_on[i] && tbl_hour[i] == r.hour &&
								tbl_minute[i] == r.minute)
							hit = i;
					end
					// the slot already latched does not fire a second time
					if (hit >= 0 && !(pending_on && int'(pending_at) == hit)) begin
						pending_on = 1'b1;
						pending_at = SLOT_W'(hit);
						res.fired = 1'b1;
						res.fired_slot = SLOT_W'(hit);
					end
				end
			end
			CMD_READ: begin
				if (idx_ok) begin
					res.slot_hour = tbl_hour[r.slot];
					res.slot_minute = tbl_minute[r.slot];
					res.slot_on = tbl_on[r.slot];
					res.slot_repeat = tbl_repeat[r.slot];
					res.ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				pending_on = 1'b0;
				pending_at = '0;
				res.ok = 1'b1;
			end
			default: ;
			endcase
		end
		res.pending = pending_on;
		res.pending_slot = pending_at;
		res.slot_count = COUNT_W'(slots_used);
		return res;
	endfunction

	function automatic alarm_req_t mk_req(input logic [CMD_W-1:0] cmd, input int slot,
			input int hour, input int minute, input logic [REP_W-1:0] rep);
		alarm_req_t r;
		r.cmd = cmd;
		r.slot = SLOT_W'(slot);
		r.hour = HOUR_W'(hour);
		r.minute = MIN_W'(minute);
		r.repeat_word = rep;
		r.drain_first = 1'b0;
		return r;
	endfunction

	// Appends one request to the sender's queue.
	function automatic void queue_request(input alarm_req_t r);
		request_queue = {request_queue, r};
	endfunction

	// Idle length for one side: mostly zero or short, a few long, with calm stretches.
	function automatic int draw_idle(inout int calm);
		int pick;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// Sender: a new request goes out once the previous one was taken and its gap ran out.
	always @(negedge clk) begin
		if (!s_tvalid || item_taken) begin
			item_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_queue.size() != 0 &&
					!(request_queue[0].drain_first && expected_results.size() != 0)) begin
				driven_req = request_queue.pop_front();
				s_tdata <= {1'b0, driven_req.repeat_word, driven_req.minute,
					driven_req.hour, driven_req.slot};
				s_tuser <= driven_req.cmd;
				s_tvalid <= 1'b1;
				gap_left = draw_idle(tx_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			stall_left = draw_idle(rx_calm);
			m_tready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Result check first, then prediction for a request taken at the same edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				got = msam_res_t'(m_tdata);
				check_field("ok", 64'(want.ok), 64'(got.ok));
				check_field("new_slot", 64'(want.new_slot), 64'(got.new_slot));
				check_field("fired", 64'(want.fired), 64'(got.fired));
				check_field("fired_slot", 64'(want.fired_slot), 64'(got.fired_slot));
				check_field("pending", 64'(want.pending), 64'(got.pending));
				check_field("pending_slot", 64'(want.pending_slot), 64'(got.pending_slot));
				check_field("slot_hour", 64'(want.slot_hour), 64'(got.slot_hour));
				check_field("slot_minute", 64'(want.slot_minute), 64'(got.slot_minute));
				check_field("slot_on", 64'(want.slot_on), 64'(got.slot_on));
				check_field("slot_repeat", 64'(want.slot_repeat), 64'(got.slot_repeat));
				check_field("slot_count", 64'(want.slot_count), 64'(got.slot_count));
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			expected_results = {expected_results, predict_alarm_result(driven_req)};
			item_taken = 1'b1;
		end
	end

	// APB write: setup, access, held until pready; predictor config follows the write.
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == REG_BLOCK_EN)
			cfg_block_en = value[0];
		else
			cfg_auto_check = value[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Idle means nothing queued, nothing on the bus and every result back.
	task automatic wait_drained();
		do @(posedge clk);
		while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Random requests. Times come mostly from a small pool so ticks hit stored alarms;
	// add and remove weights steer how full the table gets.
	task automatic queue_random(input int count, input int add_w, input int rm_w);
		alarm_req_t r;
		int         pick;
		int         p;
		for (int k = 0; k < 4; k++) begin
			pool_hour[k] = HOUR_W'($urandom_range(0, MAX_HOUR));
			pool_minute[k] = MIN_W'($urandom_range(0, MAX_MINUTE));
		end
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < add_w)
				r.cmd = CMD_ADD;
			else if (pick < add_w + rm_w)
				r.cmd = CMD_REMOVE;
			else if (pick < add_w + rm_w + 25)
				r.cmd = CMD_TICK;
			else if (pick < add_w + rm_w + 29)
				r.cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
			else
				r.cmd = CMD_W'($urandom_range(CMD_ENABLE, CMD_CLEAR));
			if ($urandom_range(0, 99) < 40)
				r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
			else
				r.slot = SLOT_W'($urandom_range(0, 5));
			pick = $urandom_range(0, 99);
			p = $urandom_range(0, 3);
			if (pick < 75) begin
				r.hour = pool_hour[p];
				r.minute = pool_minute[p];
			end else if (pick < 90) begin
				r.hour = HOUR_W'($urandom_range(0, MAX_HOUR));
				r.minute = MIN_W'($urandom_range(0, MAX_MINUTE));
			end else begin
				r.hour = HOUR_W'($urandom);
				r.minute = MIN_W'($urandom);
			end
			r.repeat_word = $urandom;
			r.drain_first = (n == 0) || ($urandom_range(0, 99) == 0);
			queue_request(r);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// block comes up disabled: everything fails, clear included
		queue_request(mk_req(CMD_ADD, 0, 7, 30, 32'h1));
		queue_request(mk_req(CMD_TICK, 0, 7, 30, 32'h0));
		queue_request(mk_req(CMD_CLEAR, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_READ, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_LAST_UNUSED, 15, 31, 63, 32'hFFFF_FFFF));
		wait_drained();
		write_reg(REG_BLOCK_EN, 32'h1);

		// directed: time limits, fire-once, lowest match, disabled slot, shift on remove
		queue_request(mk_req(CMD_ADD, 0, 23, 59, 32'hFFFF_FFFF));
		queue_request(mk_req(CMD_ADD, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_ADD, 0, 24, 0, 32'h1234_5678));
		queue_request(mk_req(CMD_ADD, 0, 12, 60, 32'h1234_5678));
		queue_request(mk_req(CMD_ADD, 0, 31, 63, 32'h8000_0001));
		queue_request(mk_req(CMD_READ, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_READ, 1, 0, 0, 32'h0));
		queue_request(mk_req(CMD_TICK, 0, 23, 59, 32'h0));
		queue_request(mk_req(CMD_TICK, 0, 23, 59, 32'h0));
		queue_request(mk_req(CMD_TICK, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_DISABLE, 1, 0, 0, 32'h0));
		queue_request(mk_req(CMD_TICK, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_TOGGLE, 1, 0, 0, 32'h0));
		queue_request(mk_req(CMD_SET_TIME, 1, 23, 59, 32'h0));
		queue_request(mk_req(CMD_SET_TIME, 0, 31, 0, 32'h0));
		queue_request(mk_req(CMD_SET_REP, 1, 0, 0, 32'hA5A5_5A5A));
		queue_request(mk_req(CMD_TICK, 0, 23, 59, 32'h0));
		queue_request(mk_req(CMD_READ, 15, 0, 0, 32'h0));
		queue_request(mk_req(CMD_REMOVE, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_READ, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_ENABLE, 14, 0, 0, 32'h0));
		queue_request(mk_req(CMD_CLEAR, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_FIRST_UNUSED, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_LAST_UNUSED, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_REMOVE, 0, 0, 0, 32'h0));
		wait_drained();

		// alarm checking off: ticks fail and leave the latch alone
		write_reg(REG_AUTO_CHECK, 32'h0);
		queue_request(mk_req(CMD_ADD, 0, 5, 5, 32'h0F0F_0F0F));
		queue_request(mk_req(CMD_TICK, 0, 5, 5, 32'h0));
		queue_request(mk_req(CMD_READ, 0, 0, 0, 32'h0));
		queue_request(mk_req(CMD_TICK, 0, 5, 5, 32'h0));
		wait_drained();
		write_reg(REG_AUTO_CHECK, 32'h1);

		// fill the table up to full, then churn it down with removes
		queue_random(300, 45, 5);
		queue_random(150, 15, 25);
		wait_drained();
		write_reg(REG_BLOCK_EN, 32'h0);
		queue_random(30, 25, 10);
		wait_drained();
		write_reg(REG_BLOCK_EN, 32'h1);
		queue_random(250, 25, 12);
		wait_drained();
		write_reg(REG_AUTO_CHECK, 32'h0);
		queue_random(20, 20, 10);
		wait_drained();
		write_reg(REG_AUTO_CHECK, 32'h1);

		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
